FILE: sv/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and codes for the run-length row decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    localparam int unsigned CfgAddrWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_ZEROLIT  = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    localparam logic REG_BPP        = 1'b0;
    localparam logic REG_ROW_PIXELS = 1'b1;

    typedef enum logic [6:0] {
        PH_LEN_LO  = 7'b0000001,
        PH_LEN_HI  = 7'b0000010,
        PH_TAG     = 7'b0000100,
        PH_REPEAT  = 7'b0001000,
        PH_LCOUNT  = 7'b0010000,
        PH_LITERAL = 7'b0100000,
        PH_DISCARD = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  bytes_per_pixel;
        logic [15:0] row_pixels;
    } t_cfg;

    typedef struct packed {
        logic [23:0] pixel_value;
        logic [7:0]  run_count;
        logic        pixel_present;
        logic        row_end;
        logic [2:0]  status;
    } t_result;

    function automatic t_phase end_phase(input logic [15:0] consumed,
                                         input logic [15:0] length);
        return (consumed >= length) ? PH_LEN_LO : PH_DISCARD;
    endfunction

endpackage

FILE: sv/rle_row_decoder.sv
// ----------------------------------------------------------------------------
// rle_row_decoder
// Run-length row decoder with literal blocks, one compressed byte per transfer.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake            Payload
//   input     in          i_valid / o_stall    i_stream_byte
//   output    out         o_valid / i_stall    o_pixel_value, o_run_count,
//                                              o_pixel_present, o_row_end, o_status
//   config    in          APB psel / penable   paddr, pwdata, prdata
//
// A byte is registered on input and then decoded into the result register, so
// one byte is taken every cycle unless a byte that yields a result waits on
// a stalled output. The result register is the only point of back-pressure.
// A byte that yields no result is decoded even while the output is stalled.
// Reset returns the decoder to expecting a row length and restores defaults.
// ----------------------------------------------------------------------------
module rle_row_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_stream_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [23:0]                         o_pixel_value,
    output logic [7:0]                          o_run_count,
    output logic                                o_pixel_present,
    output logic                                o_row_end,
    output logic [2:0]                          o_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rld_pkg::CfgAddrWidth-1:0]    paddr,
    input  logic [rld_pkg::CfgDataWidth-1:0]    pwdata,
    output logic [rld_pkg::CfgDataWidth-1:0]    prdata,
    output logic                                pready
);
    import rld_pkg::*;

    t_cfg     cfg;
    t_result  core_result;
    t_result  r_result;
    logic     core_has_result;
    logic     r_in_valid;
    logic [7:0] r_in_byte;
    logic     r_out_valid;
    logic     out_free;
    logic     advance;
    logic     in_take;

    rld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rld_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_cfg        (cfg),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (out_free || !core_has_result);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_has_result) begin
            r_result <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_value   = r_result.pixel_value;
    assign o_run_count     = r_result.run_count;
    assign o_pixel_present = r_result.pixel_present;
    assign o_row_end       = r_result.row_end;
    assign o_status        = r_result.status;

endmodule

FILE: sv/rld_cfg.sv
// ----------------------------------------------------------------------------
// rld_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module rld_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rld_pkg::CfgAddrWidth-1:0]    paddr,
    input  logic [rld_pkg::CfgDataWidth-1:0]    pwdata,
    output logic [rld_pkg::CfgDataWidth-1:0]    prdata,
    output logic                                pready,
    output rld_pkg::t_cfg                       o_cfg
);
    import rld_pkg::*;

    logic [1:0]  r_bpp;
    logic [15:0] r_row_pixels;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= 2'd1;
            r_row_pixels <= 16'd1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_BPP:        r_bpp        <= pwdata[1:0];
                REG_ROW_PIXELS: r_row_pixels <= pwdata[15:0];
                default:        r_bpp        <= r_bpp;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BPP:        prdata = {{(CfgDataWidth-2){1'b0}}, r_bpp};
            REG_ROW_PIXELS: prdata = {{(CfgDataWidth-16){1'b0}}, r_row_pixels};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.bytes_per_pixel = r_bpp;
    assign o_cfg.row_pixels      = r_row_pixels;

endmodule

FILE: sv/rld_core.sv
// ----------------------------------------------------------------------------
// rld_core
// Decode state and the single-pass next-state and result logic per byte.
// ----------------------------------------------------------------------------
module rld_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  rld_pkg::t_cfg    i_cfg,
    output logic             o_has_result,
    output rld_pkg::t_result o_result
);
    import rld_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_row_length, n_row_length;
    logic [15:0] r_consumed, n_consumed;
    logic [15:0] r_filled, n_filled;
    logic [23:0] r_collector, n_collector;
    logic [1:0]  r_byte_idx, n_byte_idx;
    logic [7:0]  r_block_count, n_block_count;
    logic [7:0]  r_lit_left, n_lit_left;

    logic [1:0]  bpp;
    logic [15:0] consumed_inc;
    logic [23:0] collected;
    logic [9:0]  lit_bytes;
    logic [16:0] tag_need;
    logic [16:0] lit_need;
    logic [16:0] fill_need;
    logic [15:0] filled_sum;
    logic [7:0]  cnt;
    logic        more;

    assign bpp          = (i_cfg.bytes_per_pixel == 2'd0) ? 2'd1 : i_cfg.bytes_per_pixel;
    assign consumed_inc = r_consumed + 16'd1;
    assign collected    = {r_collector[15:0], i_byte};
    assign lit_bytes    = {2'b00, i_byte} * {8'h00, bpp};
    assign tag_need     = {1'b0, consumed_inc} + {15'd0, bpp};
    assign lit_need     = {1'b0, consumed_inc} + {7'd0, lit_bytes};
    assign fill_need    = {1'b0, r_filled} + {9'd0, i_byte};

    always_comb begin
        n_phase       = r_phase;
        n_row_length  = r_row_length;
        n_consumed    = r_consumed;
        n_filled      = r_filled;
        n_collector   = r_collector;
        n_byte_idx    = r_byte_idx;
        n_block_count = r_block_count;
        n_lit_left    = r_lit_left;
        o_has_result  = 1'b0;
        o_result      = '0;
        cnt           = 8'd0;
        more          = 1'b0;
        filled_sum    = 16'd0;

        unique case (r_phase)
            PH_LEN_LO: begin
                n_row_length = {8'h00, i_byte};
                n_phase      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_row_length = {i_byte, r_row_length[7:0]};
                n_consumed   = 16'd0;
                n_filled     = 16'd0;
                n_collector  = 24'd0;
                n_byte_idx   = 2'd0;
                if (i_cfg.row_pixels == 16'd0) begin
                    n_phase         = end_phase(16'd0, n_row_length);
                    o_has_result    = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status = ST_OK;
                end else if (n_row_length == 16'd0) begin
                    n_phase         = PH_LEN_LO;
                    o_has_result    = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status = ST_SHORT;
                end else begin
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                n_consumed = consumed_inc;
                if (i_byte != 8'd0) begin
                    n_block_count = i_byte;
                    if (tag_need > {1'b0, r_row_length}) begin
                        n_phase          = end_phase(consumed_inc, r_row_length);
                        o_has_result     = 1'b1;
                        o_result.row_end = 1'b1;
                        o_result.status  = ST_TRUNC;
                    end else if (fill_need > {1'b0, i_cfg.row_pixels}) begin
                        n_phase          = end_phase(consumed_inc, r_row_length);
                        o_has_result     = 1'b1;
                        o_result.row_end = 1'b1;
                        o_result.status  = ST_OVERFLOW;
                    end else begin
                        n_byte_idx  = 2'd0;
                        n_collector = 24'd0;
                        n_phase     = PH_REPEAT;
                    end
                end else if (consumed_inc >= r_row_length) begin
                    n_phase          = PH_LEN_LO;
                    o_has_result     = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status  = ST_TRUNC;
                end else begin
                    n_phase = PH_LCOUNT;
                end
            end
            PH_LCOUNT: begin
                n_consumed = consumed_inc;
                if (i_byte == 8'd0) begin
                    n_phase          = end_phase(consumed_inc, r_row_length);
                    o_has_result     = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status  = ST_ZEROLIT;
                end else if (lit_need > {1'b0, r_row_length}) begin
                    n_phase          = end_phase(consumed_inc, r_row_length);
                    o_has_result     = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status  = ST_TRUNC;
                end else if (fill_need > {1'b0, i_cfg.row_pixels}) begin
                    n_phase          = end_phase(consumed_inc, r_row_length);
                    o_has_result     = 1'b1;
                    o_result.row_end = 1'b1;
                    o_result.status  = ST_OVERFLOW;
                end else begin
                    n_lit_left  = i_byte;
                    n_byte_idx  = 2'd0;
                    n_collector = 24'd0;
                    n_phase     = PH_LITERAL;
                end
            end
            PH_REPEAT, PH_LITERAL: begin
                n_consumed = consumed_inc;
                if (({1'b0, r_byte_idx} + 3'd1) < {1'b0, bpp}) begin
                    n_byte_idx  = r_byte_idx + 2'd1;
                    n_collector = collected;
                    if (consumed_inc >= r_row_length) begin
                        n_phase          = PH_LEN_LO;
                        o_has_result     = 1'b1;
                        o_result.row_end = 1'b1;
                        o_result.status  = ST_TRUNC;
                    end
                end else begin
                    n_byte_idx  = 2'd0;
                    n_collector = 24'd0;
                    if (r_phase == PH_REPEAT) begin
                        cnt  = r_block_count;
                        more = 1'b0;
                    end else begin
                        cnt        = 8'd1;
                        n_lit_left = r_lit_left - 8'd1;
                        more       = (n_lit_left != 8'd0);
                    end
                    filled_sum             = r_filled + {8'h00, cnt};
                    n_filled               = filled_sum;
                    o_has_result           = 1'b1;
                    o_result.pixel_value   = collected;
                    o_result.run_count     = cnt;
                    o_result.pixel_present = 1'b1;
                    if (filled_sum >= i_cfg.row_pixels) begin
                        n_phase          = end_phase(consumed_inc, r_row_length);
                        o_result.row_end = 1'b1;
                        o_result.status  = ST_OK;
                    end else if (consumed_inc >= r_row_length) begin
                        n_phase          = PH_LEN_LO;
                        o_result.row_end = 1'b1;
                        o_result.status  = more ? ST_TRUNC : ST_SHORT;
                    end else if (!more) begin
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_DISCARD: begin
                n_consumed = consumed_inc;
                if (consumed_inc >= r_row_length) begin
                    n_phase = PH_LEN_LO;
                end
            end
            default: begin
                n_phase = PH_LEN_LO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEN_LO;
            r_row_length  <= 16'd0;
            r_consumed    <= 16'd0;
            r_filled      <= 16'd0;
            r_collector   <= 24'd0;
            r_byte_idx    <= 2'd0;
            r_block_count <= 8'd0;
            r_lit_left    <= 8'd0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_row_length  <= n_row_length;
            r_consumed    <= n_consumed;
            r_filled      <= n_filled;
            r_collector   <= n_collector;
            r_byte_idx    <= n_byte_idx;
            r_block_count <= n_block_count;
            r_lit_left    <= n_lit_left;
        end
    end

endmodule

FILE: tb/sv/rld_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rld_run_checker
// Follows the row decoder's state from its input transfers and register
// writes, predicts every run record, and compares each output transfer with
// the oldest predicted record, field by field.
// ----------------------------------------------------------------------------
module rld_run_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [7:0]                          i_in_byte,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [23:0]                         i_pixel_value,
    input  logic [7:0]                          i_run_count,
    input  logic                                i_pixel_present,
    input  logic                                i_row_end,
    input  logic [2:0]                          i_status,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [rld_pkg::CfgAddrWidth-1:0]    i_paddr,
    input  logic [rld_pkg::CfgDataWidth-1:0]    i_pwdata,
    input  logic                                i_pready,
    output int                                  o_mismatches,
    output int                                  o_pending
);

    import rld_pkg::*;

    logic [1:0]  cfg_bpp;
    logic [15:0] cfg_row_pixels;

    t_phase      phase;
    logic [15:0] row_length;
    logic [15:0] bytes_consumed;
    logic [15:0] pixels_filled;
    logic [23:0] collector;
    logic [1:0]  byte_in_pixel;
    logic [7:0]  block_count;
    logic [7:0]  literals_left;

    t_result     expected_runs[$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic push_run(input logic [23:0] pix, input logic [7:0] cnt,
                            input logic present, input logic rend,
                            input logic [2:0] st);
        t_result r;
        r.pixel_value   = pix;
        r.run_count     = cnt;
        r.pixel_present = present;
        r.row_end       = rend;
        r.status        = st;
        expected_runs.push_back(r);
    endtask

    task automatic finish_row();
        phase = (bytes_consumed >= row_length) ? PH_LEN_LO : PH_DISCARD;
    endtask

    task automatic abandon_row(input logic [2:0] st);
        finish_row();
        push_run(24'd0, 8'd0, 1'b0, 1'b1, st);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int unsigned bpp;
        logic [23:0] pix;
        logic [7:0]  cnt;
        logic        more;
        bpp = (cfg_bpp == 2'd0) ? 1 : 32'(cfg_bpp);
        case (phase)
            PH_LEN_LO: begin
                row_length = {8'h00, b};
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                row_length[15:8] = b;
                bytes_consumed = '0;
                pixels_filled  = '0;
                collector      = '0;
                byte_in_pixel  = '0;
                if (cfg_row_pixels == 16'd0)
                    abandon_row(ST_OK);
                else if (row_length == 16'd0)
                    abandon_row(ST_SHORT);
                else
                    phase = PH_TAG;
            end
            PH_TAG: begin
                bytes_consumed = bytes_consumed + 16'd1;
                if (b != 8'd0) begin
                    block_count = b;
                    if (32'(bytes_consumed) + bpp > 32'(row_length)) begin
                        abandon_row(ST_TRUNC);
                    end else if (32'(pixels_filled) + 32'(b) > 32'(cfg_row_pixels)) begin
                        abandon_row(ST_OVERFLOW);
                    end else begin
                        byte_in_pixel = '0;
                        collector     = '0;
                        phase         = PH_REPEAT;
                    end
                end else if (bytes_consumed >= row_length) begin
                    abandon_row(ST_TRUNC);
                end else begin
                    phase = PH_LCOUNT;
                end
            end
            PH_LCOUNT: begin
                bytes_consumed = bytes_consumed + 16'd1;
                if (b == 8'd0) begin
                    abandon_row(ST_ZEROLIT);
                end else if (32'(bytes_consumed) + 32'(b) * bpp > 32'(row_length)) begin
                    abandon_row(ST_TRUNC);
                end else if (32'(pixels_filled) + 32'(b) > 32'(cfg_row_pixels)) begin
                    abandon_row(ST_OVERFLOW);
                end else begin
                    literals_left = b;
                    byte_in_pixel = '0;
                    collector     = '0;
                    phase         = PH_LITERAL;
                end
            end
            PH_REPEAT, PH_LITERAL: begin
                bytes_consumed = bytes_consumed + 16'd1;
                collector = {collector[15:0], b};
                if (32'(byte_in_pixel) + 1 < bpp) begin
                    byte_in_pixel = byte_in_pixel + 2'd1;
                    if (bytes_consumed >= row_length)
                        abandon_row(ST_TRUNC);
                end else begin
                    byte_in_pixel = '0;
                    pix = collector;
                    collector = '0;
                    if (phase == PH_REPEAT) begin
                        cnt  = block_count;
                        more = 1'b0;
                    end else begin
                        cnt = 8'd1;
                        literals_left = literals_left - 8'd1;
                        more = (literals_left != 8'd0);
                    end
                    pixels_filled = pixels_filled + 16'(cnt);
                    if (pixels_filled >= cfg_row_pixels) begin
                        finish_row();
                        push_run(pix, cnt, 1'b1, 1'b1, ST_OK);
                    end else if (bytes_consumed >= row_length) begin
                        finish_row();
                        push_run(pix, cnt, 1'b1, 1'b1, more ? ST_TRUNC : ST_SHORT);
                    end else begin
                        if (!more)
                            phase = PH_TAG;
                        push_run(pix, cnt, 1'b1, 1'b0, ST_OK);
                    end
                end
            end
            PH_DISCARD: begin
                bytes_consumed = bytes_consumed + 16'd1;
                if (bytes_consumed >= row_length)
                    phase = PH_LEN_LO;
            end
            default: begin
                phase = PH_LEN_LO;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_val,
                               input logic [23:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_bpp        = 2'd1;
            cfg_row_pixels = 16'd1;
            phase          = PH_LEN_LO;
            row_length     = '0;
            bytes_consumed = '0;
            pixels_filled  = '0;
            collector      = '0;
            byte_in_pixel  = '0;
            block_count    = '0;
            literals_left  = '0;
            expected_runs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("run record with no expectation: pixel 0x%0h count %0d status %0d",
                           i_pixel_value, i_run_count, i_status);
                    mismatch_count++;
                end else begin
                    want = expected_runs.pop_front();
                    check_field("pixel_value", want.pixel_value, i_pixel_value);
                    check_field("run_count", 24'(want.run_count), 24'(i_run_count));
                    check_field("pixel_present", 24'(want.pixel_present),
                                24'(i_pixel_present));
                    check_field("row_end", 24'(want.row_end), 24'(i_row_end));
                    check_field("status", 24'(want.status), 24'(i_status));
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_byte(i_in_byte);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_BPP)
                    cfg_bpp = i_pwdata[1:0];
                else if (i_paddr[2] == REG_ROW_PIXELS)
                    cfg_row_pixels = i_pwdata[15:0];
            end
        end
        o_pending <= expected_runs.size();
    end

endmodule

FILE: tb/sv/tb_rle_row_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_row_decoder
// Feeds the row decoder with hand-built rows for every status and corner case,
// then with random rows, mostly well formed, under several pixel formats and
// row sizes. Input transfers come in bursts and the output stalls in patterns
// of its own; the checker beside the block judges every run record.
// ----------------------------------------------------------------------------
module tb_rle_row_decoder;

    import rld_pkg::*;

    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RANDOM_BYTES  = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 5000;

    typedef enum int unsigned {
        ROW_CLEAN,
        ROW_OVERFLOW,
        ROW_SHORT,
        ROW_NOISE,
        ROW_ZERO_LIT,
        ROW_PADDED,
        ROW_TRUNCATED
    } row_kind_e;

    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_e;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [7:0]               in_byte   = 8'h00;
    logic                     out_stall = 1'b0;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [CfgAddrWidth-1:0]  paddr     = '0;
    logic [CfgDataWidth-1:0]  pwdata    = '0;

    logic                     in_stall;
    logic                     out_valid;
    logic [23:0]              pixel_value;
    logic [7:0]               run_count;
    logic                     pixel_present;
    logic                     row_end;
    logic [2:0]               status;
    logic [CfgDataWidth-1:0]  prdata;
    logic                     pready;

    int                       mismatches;
    int                       pending;

    logic [7:0]               stream_bytes[$];
    int unsigned              bytes_sent   = 0;
    int unsigned              burst_left   = 0;
    int unsigned              cycle_count  = 0;
    logic [1:0]               cur_bpp      = 2'd1;
    int unsigned              cur_rows     = 1;
    stall_mode_e              stall_mode   = STALL_NONE;
    int unsigned              stall_left   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    rle_row_decoder i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_stream_byte   (in_byte),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_pixel_value   (pixel_value),
        .o_run_count     (run_count),
        .o_pixel_present (pixel_present),
        .o_row_end       (row_end),
        .o_status        (status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    rld_run_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_byte       (in_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_pixel_value   (pixel_value),
        .i_run_count     (run_count),
        .i_pixel_present (pixel_present),
        .i_row_end       (row_end),
        .i_status        (status),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= stall_mode_e'($urandom_range(0, 2));
            stall_left <= $urandom_range(20, 80);
            out_stall  <= 1'b0;
        end else begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
                default:     out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_bytes();
        int unsigned gap_len;
        while (stream_bytes.size() != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap_len != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap_len) @(posedge clk);
                end
            end
            in_valid <= 1'b1;
            in_byte  <= stream_bytes.pop_front();
            @(posedge clk);
            while (in_stall) @(posedge clk);
            burst_left--;
            bytes_sent++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [CfgAddrWidth-1:0] addr,
                             input logic [CfgDataWidth-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic build_row();
        logic [7:0]  body[$];
        row_kind_e   kind;
        int unsigned pick;
        int unsigned bpp;
        int unsigned target;
        int unsigned filled;
        int unsigned blocks;
        int unsigned max_blocks;
        int unsigned zero_at;
        int unsigned room;
        int unsigned cnt;
        int unsigned len;
        pick = $urandom_range(0, 13);
        kind = (pick > 6) ? ROW_CLEAN : row_kind_e'(pick);
        bpp = (cur_bpp == 2'd0) ? 1 : 32'(cur_bpp);
        target = cur_rows;
        if (kind == ROW_OVERFLOW)
            target = cur_rows + $urandom_range(1, 20);
        if (kind == ROW_SHORT && cur_rows > 1)
            target = $urandom_range(1, cur_rows - 1);
        max_blocks = (cur_rows > 40) ? 12 : 40;
        zero_at = $urandom_range(0, 2);
        filled = 0;
        blocks = 0;
        if (kind == ROW_NOISE) begin
            repeat ($urandom_range(0, 12)) body.push_back(rand_byte());
        end else begin
            while (filled < target && blocks < max_blocks) begin
                if (kind == ROW_ZERO_LIT && blocks == zero_at) begin
                    body.push_back(8'h00);
                    body.push_back(8'h00);
                end else begin
                    room = target - filled;
                    if (room > 255)
                        room = 255;
                    if ($urandom_range(0, 1) == 0) begin
                        cnt = $urandom_range(1, room);
                        body.push_back(8'(cnt));
                        repeat (bpp) body.push_back(rand_byte());
                    end else begin
                        if (room > 6)
                            room = 6;
                        cnt = $urandom_range(1, room);
                        body.push_back(8'h00);
                        body.push_back(8'(cnt));
                        repeat (cnt * bpp) body.push_back(rand_byte());
                    end
                    filled += cnt;
                end
                blocks++;
            end
        end
        if (kind == ROW_PADDED)
            repeat ($urandom_range(1, 4)) body.push_back(rand_byte());
        len = body.size();
        if (kind == ROW_TRUNCATED && len > 0)
            len = $urandom_range(0, len - 1);
        stream_bytes.push_back(8'(len));
        stream_bytes.push_back(8'(len >> 8));
        for (int unsigned i = 0; i < len; i++)
            stream_bytes.push_back(body[i]);
    endtask

    initial begin
        int unsigned drain_cycles;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stream_bytes = '{8'h02, 8'h00, 8'h01, 8'hFF};
        send_bytes();
        settle();
        apb_write({REG_ROW_PIXELS, 2'b00}, 32'd3);
        cur_rows = 3;
        stream_bytes = '{8'h00, 8'h00,
                         8'h04, 8'h00, 8'h03, 8'h00, 8'hAA, 8'h55,
                         8'h02, 8'h00, 8'h00, 8'h00,
                         8'h02, 8'h00, 8'h04, 8'h11,
                         8'h01, 8'h00, 8'h05,
                         8'h02, 8'h00, 8'h01, 8'h22,
                         8'h05, 8'h00, 8'h00, 8'h03, 8'h01, 8'h02, 8'h03};
        send_bytes();
        settle();
        apb_write({REG_BPP, 2'b00}, 32'd0);
        apb_write({REG_ROW_PIXELS, 2'b00}, 32'd0);
        stream_bytes = '{8'h01, 8'h00, 8'h7F};
        send_bytes();
        settle();
        apb_write({REG_BPP, 2'b00}, 32'd3);
        apb_write({REG_ROW_PIXELS, 2'b00}, 32'd65535);
        stream_bytes = '{8'h04, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56};
        send_bytes();
        settle();
        // A wider pixel format mid-pixel makes the pixel overrun the row.
        apb_write({REG_BPP, 2'b00}, 32'd2);
        apb_write({REG_ROW_PIXELS, 2'b00}, 32'd2);
        stream_bytes = '{8'h03, 8'h00, 8'h01, 8'hB1};
        send_bytes();
        settle();
        apb_write({REG_BPP, 2'b00}, 32'd3);
        stream_bytes = '{8'hB2};
        send_bytes();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            settle();
            cur_bpp = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       cur_rows = 0;
                1:       cur_rows = 1;
                2:       cur_rows = 65535;
                default: cur_rows = $urandom_range(2, 40);
            endcase
            apb_write({REG_BPP, 2'b00}, 32'(cur_bpp));
            apb_write({REG_ROW_PIXELS, 2'b00}, 32'(cur_rows));
            repeat ($urandom_range(2, 6)) build_row();
            send_bytes();
        end

        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rld_pkg.sv
sv/rld_cfg.sv
sv/rld_core.sv
sv/rle_row_decoder.sv
tb/sv/rld_run_checker.sv
tb/sv/tb_rle_row_decoder.sv
